FILE: design/scma_pkg.sv
// ----------------------------------------------------------------------------
// Sector chain map allocator package
// Shared widths, codes and word types for the allocator and its submodules.
// ----------------------------------------------------------------------------
package scma_pkg;

  localparam int MAX_DATA_SECTORS = 4096;
  localparam int OFF_W            = $clog2(MAX_DATA_SECTORS);
  localparam int LINK_W           = OFF_W + 1;
  localparam int SECTOR_W         = 16;
  localparam int ACTION_W         = 3;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 16;
  localparam int OP_W             = 5;

  localparam logic [LINK_W-1:0] END_MARK  = LINK_W'(MAX_DATA_SECTORS);
  localparam logic [LINK_W-1:0] MAX_COUNT = LINK_W'(MAX_DATA_SECTORS);

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_COUNT = 1'd1;

  localparam logic [ACTION_W-1:0] ACT_FORMAT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_NEXT   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_MARK   = 3'd5;

  localparam logic [OP_W-1:0] OP_NOP        = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD       = 5'd1;
  localparam logic [OP_W-1:0] OP_FMT_STEP   = 5'd2;
  localparam logic [OP_W-1:0] OP_FMT_LAST   = 5'd3;
  localparam logic [OP_W-1:0] OP_FMT_EMPTY  = 5'd4;
  localparam logic [OP_W-1:0] OP_ALLOC_RD   = 5'd5;
  localparam logic [OP_W-1:0] OP_ALLOC_WR   = 5'd6;
  localparam logic [OP_W-1:0] OP_FAIL_END   = 5'd7;
  localparam logic [OP_W-1:0] OP_FAIL       = 5'd8;
  localparam logic [OP_W-1:0] OP_FREE       = 5'd9;
  localparam logic [OP_W-1:0] OP_NEXT_RD    = 5'd10;
  localparam logic [OP_W-1:0] OP_NEXT_RES   = 5'd11;
  localparam logic [OP_W-1:0] OP_MARK       = 5'd12;
  localparam logic [OP_W-1:0] OP_WALK_START = 5'd13;
  localparam logic [OP_W-1:0] OP_WALK_STEP  = 5'd14;
  localparam logic [OP_W-1:0] OP_APP_LINK   = 5'd15;
  localparam logic [OP_W-1:0] OP_APP_TAIL   = 5'd16;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SECTOR_W-1:0] sector;
    logic [SECTOR_W-1:0] chain_head;
    logic                head_is_end;
  } in_word_t;

  typedef struct packed {
    logic                ok;
    logic [SECTOR_W-1:0] result_sector;
    logic                result_is_end;
    logic [LINK_W-1:0]   free_count;
  } out_word_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                head_is_end;
    logic                sec_ok;
    logic                head_ok;
    logic                fh_ok;
    logic                fmt_last;
    logic                link_more;
    logic                walk_more;
  } dp_stat_t;

endpackage

FILE: design/scma_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module scma_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/scma_dp.sv
// ----------------------------------------------------------------------------
// Allocator datapath
// Configuration, request, free list registers, link table and result word.
// ----------------------------------------------------------------------------
module scma_dp import scma_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_word_t              in_word,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  output out_word_t             out_word
);

  logic [SECTOR_W-1:0] dbase_r, dbase_nxt;
  logic [LINK_W-1:0]   dcount_r, dcount_nxt;
  in_word_t            req_r, req_nxt;
  logic [LINK_W-1:0]   fh_r, fh_nxt;
  logic [LINK_W-1:0]   total_r, total_nxt;
  logic [LINK_W-1:0]   step_r, step_nxt;
  logic [OFF_W-1:0]    cur_r, cur_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;

  logic [LINK_W-1:0]   n_eff;
  logic [SECTOR_W-1:0] n_wide;
  logic [SECTOR_W-1:0] sec_diff, head_diff;
  logic [OFF_W-1:0]    sec_off, head_off;
  logic [LINK_W-1:0]   step_inc;
  logic [LINK_W-1:0]   fmt_link;
  logic                fmt_last;
  logic                link_more;

  logic                ram_we, ram_re;
  logic [OFF_W-1:0]    ram_waddr, ram_raddr;
  logic [LINK_W-1:0]   ram_wdata, ram_rdata;

  logic                res_ok, res_end;
  logic [SECTOR_W-1:0] res_sec;

  function automatic logic [SECTOR_W-1:0] to_abs(input logic [SECTOR_W-1:0] base,
                                                 input logic [OFF_W-1:0] off);
    to_abs = base + {{(SECTOR_W-OFF_W){1'b0}}, off};
  endfunction

  assign n_eff     = (dcount_r > MAX_COUNT) ? MAX_COUNT : dcount_r;
  assign n_wide    = {{(SECTOR_W-LINK_W){1'b0}}, n_eff};
  assign sec_diff  = req_r.sector - dbase_r;
  assign head_diff = req_r.chain_head - dbase_r;
  assign sec_off   = sec_diff[OFF_W-1:0];
  assign head_off  = head_diff[OFF_W-1:0];
  assign step_inc  = step_r + LINK_W'(1);
  assign fmt_last  = step_inc >= n_eff;
  assign fmt_link  = fmt_last ? END_MARK : step_inc;
  assign link_more = ram_rdata < n_eff;

  assign stat.action      = req_r.action;
  assign stat.head_is_end = req_r.head_is_end;
  assign stat.sec_ok      = sec_diff < n_wide;
  assign stat.head_ok     = head_diff < n_wide;
  assign stat.fh_ok       = fh_r < n_eff;
  assign stat.fmt_last    = fmt_last;
  assign stat.link_more   = link_more;
  assign stat.walk_more   = step_r < n_eff;

  always_comb begin
    dbase_nxt  = dbase_r;
    dcount_nxt = dcount_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DATA_BASE:  dbase_nxt  = cfg_wdata;
        CFG_DATA_COUNT: dcount_nxt = cfg_wdata[LINK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    req_nxt       = req_r;
    fh_nxt        = fh_r;
    total_nxt     = total_r;
    step_nxt      = step_r;
    cur_nxt       = cur_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = sec_off;
    ram_raddr     = sec_off;
    ram_wdata     = END_MARK;
    out_valid_nxt = 1'b0;
    res_ok        = 1'b0;
    res_end       = 1'b0;
    res_sec       = '0;
    case (cmd.op)
      OP_LOAD: begin
        req_nxt  = in_word;
        step_nxt = '0;
      end
      OP_FMT_STEP: begin
        ram_we    = 1'b1;
        ram_waddr = step_r[OFF_W-1:0];
        ram_wdata = fmt_link;
        step_nxt  = step_inc;
      end
      OP_FMT_LAST: begin
        ram_we        = 1'b1;
        ram_waddr     = step_r[OFF_W-1:0];
        ram_wdata     = fmt_link;
        fh_nxt        = '0;
        total_nxt     = n_eff;
        out_valid_nxt = 1'b1;
        res_ok        = 1'b1;
      end
      OP_FMT_EMPTY: begin
        fh_nxt        = END_MARK;
        total_nxt     = '0;
        out_valid_nxt = 1'b1;
        res_ok        = 1'b1;
      end
      OP_ALLOC_RD: begin
        ram_re    = 1'b1;
        ram_raddr = fh_r[OFF_W-1:0];
      end
      OP_ALLOC_WR: begin
        ram_we        = 1'b1;
        ram_waddr     = fh_r[OFF_W-1:0];
        ram_wdata     = END_MARK;
        fh_nxt        = ram_rdata;
        total_nxt     = (total_r != '0) ? total_r - LINK_W'(1) : total_r;
        out_valid_nxt = 1'b1;
        res_ok        = 1'b1;
        res_sec       = to_abs(dbase_r, fh_r[OFF_W-1:0]);
      end
      OP_FAIL_END: begin
        out_valid_nxt = 1'b1;
        res_end       = 1'b1;
      end
      OP_FAIL: begin
        out_valid_nxt = 1'b1;
      end
      OP_FREE: begin
        ram_we        = 1'b1;
        ram_waddr     = sec_off;
        ram_wdata     = fh_r;
        fh_nxt        = {1'b0, sec_off};
        total_nxt     = (total_r < n_eff) ? total_r + LINK_W'(1) : total_r;
        out_valid_nxt = 1'b1;
        res_ok        = 1'b1;
      end
      OP_NEXT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = sec_off;
      end
      OP_NEXT_RES: begin
        out_valid_nxt = 1'b1;
        res_ok        = 1'b1;
        if (link_more) begin
          res_sec = to_abs(dbase_r, ram_rdata[OFF_W-1:0]);
        end else begin
          res_end = 1'b1;
        end
      end
      OP_MARK: begin
        ram_we        = 1'b1;
        ram_waddr     = sec_off;
        ram_wdata     = END_MARK;
        out_valid_nxt = 1'b1;
        res_ok        = 1'b1;
      end
      OP_WALK_START: begin
        ram_re    = 1'b1;
        ram_raddr = head_off;
        cur_nxt   = head_off;
        step_nxt  = '0;
      end
      OP_WALK_STEP: begin
        ram_re    = 1'b1;
        ram_raddr = ram_rdata[OFF_W-1:0];
        cur_nxt   = ram_rdata[OFF_W-1:0];
        step_nxt  = step_inc;
      end
      OP_APP_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = {1'b0, sec_off};
      end
      OP_APP_TAIL: begin
        ram_we        = 1'b1;
        ram_waddr     = sec_off;
        ram_wdata     = END_MARK;
        out_valid_nxt = 1'b1;
        res_ok        = 1'b1;
        res_sec       = to_abs(dbase_r, sec_off);
      end
      default: ;
    endcase
    if (out_valid_nxt) begin
      out_word_nxt = '{ok: res_ok, result_sector: res_sec, result_is_end: res_end,
                       free_count: total_nxt};
    end else begin
      out_word_nxt = out_word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbase_r     <= SECTOR_W'(2);
      dcount_r    <= MAX_COUNT;
      fh_r        <= END_MARK;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      dbase_r     <= dbase_nxt;
      dcount_r    <= dcount_nxt;
      fh_r        <= fh_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    step_r     <= step_nxt;
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
  end

  scma_ram #(
    .WIDTH(LINK_W),
    .DEPTH(MAX_DATA_SECTORS)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: design/scma_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences each action as datapath operations, one per cycle.
// ----------------------------------------------------------------------------
module scma_ctrl import scma_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_FMT      = 3'd2;
  localparam logic [2:0] S_ALLOC    = 3'd3;
  localparam logic [2:0] S_NEXT     = 3'd4;
  localparam logic [2:0] S_WALK     = 3'd5;
  localparam logic [2:0] S_APP_TAIL = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        case (stat.action)
          ACT_FORMAT: begin
            if (!stat.walk_more) begin
              cmd.op = OP_FMT_EMPTY;
            end else if (stat.fmt_last) begin
              cmd.op = OP_FMT_LAST;
            end else begin
              cmd.op    = OP_FMT_STEP;
              state_nxt = S_FMT;
            end
          end
          ACT_ALLOC: begin
            if (stat.fh_ok) begin
              cmd.op    = OP_ALLOC_RD;
              state_nxt = S_ALLOC;
            end else begin
              cmd.op = OP_FAIL_END;
            end
          end
          ACT_FREE: begin
            cmd.op = stat.sec_ok ? OP_FREE : OP_FAIL;
          end
          ACT_NEXT: begin
            if (stat.sec_ok) begin
              cmd.op    = OP_NEXT_RD;
              state_nxt = S_NEXT;
            end else begin
              cmd.op = OP_FAIL_END;
            end
          end
          ACT_APPEND: begin
            if (!stat.sec_ok) begin
              cmd.op = OP_FAIL;
            end else if (stat.head_is_end) begin
              cmd.op = OP_APP_TAIL;
            end else if (!stat.head_ok) begin
              cmd.op = OP_FAIL;
            end else begin
              cmd.op    = OP_WALK_START;
              state_nxt = S_WALK;
            end
          end
          ACT_MARK: begin
            cmd.op = stat.sec_ok ? OP_MARK : OP_FAIL;
          end
          default: begin
            cmd.op = OP_FAIL;
          end
        endcase
      end
      S_FMT: begin
        if (stat.fmt_last) begin
          cmd.op    = OP_FMT_LAST;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_FMT_STEP;
        end
      end
      S_ALLOC: begin
        cmd.op    = OP_ALLOC_WR;
        state_nxt = S_IDLE;
      end
      S_NEXT: begin
        cmd.op    = OP_NEXT_RES;
        state_nxt = S_IDLE;
      end
      S_WALK: begin
        if (stat.link_more && stat.walk_more) begin
          cmd.op = OP_WALK_STEP;
        end else if (stat.link_more) begin
          cmd.op    = OP_FAIL;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_APP_LINK;
          state_nxt = S_APP_TAIL;
        end
      end
      S_APP_TAIL: begin
        cmd.op    = OP_APP_TAIL;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: design/sector_chain_map_allocator.sv
// ----------------------------------------------------------------------------
// Sector chain map allocator
// FAT-style link table over the data sectors with a free list threaded
// through it: format, allocate, free, next, append and mark end.
//
//   channel   ports                              word
//   input     start, busy, in_word               action, sector, chain_head, head_is_end
//   result    out_valid, out_word                ok, sector, end, free count
//   config    cfg_we, cfg_index, cfg_wdata       data_base, data_count
//
// A word is taken when start is high and busy is low; the next word can be
// taken in the cycle its result is shown. Free, mark end, actions that fail at
// decode and an append to an empty chain finish at decode; allocate and next
// add one registered read of the link table RAM. Format writes one entry per
// cycle (an empty data area finishes at decode); append follows the links, then
// writes the link and the tail, or fails when no end is found in n links.
// Reset leaves the table undefined until a format; the result strobe lasts one
// cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module sector_chain_map_allocator import scma_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word,
  output logic                  out_valid,
  output out_word_t             out_word
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  scma_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  scma_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_word  (in_word),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_word (out_word)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("Accepted word did not make the block busy.");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result shown while the controller is still busy.");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe lasted more than one cycle.");

  a_zero_sector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_word.ok || out_word.result_is_end) |-> out_word.result_sector == '0)
    else $error("Failed or end result carries a nonzero sector.");
`endif

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Sector chain map allocator testbench
// A short table of directed words, then random phases that each set the data
// base and count and then mostly run format, allocate, free, next, append
// and mark-end sequences. Every result word is compared field by field with
// the word that an in-bench model of the link table and free list predicts, or for typed rows with the row's word.
// ----------------------------------------------------------------------------
module tb;
  import scma_pkg::*;

  localparam int RANDOM_WORDS = 1600;
  localparam int CALM_TAIL    = 200;
  localparam int RECENT_DEPTH = 16;
  localparam logic [ACTION_W-1:0] ACT_BAD_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_BAD_B = 3'd7;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    in_word_t              w;
    logic                  typed;
    out_word_t             want;
  } plan_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  out_word_t             out_word;

  logic [LINK_W-1:0]   link_model [MAX_DATA_SECTORS];
  bit                  entry_set  [MAX_DATA_SECTORS];
  logic [LINK_W-1:0]   free_head  = END_MARK;
  logic [LINK_W-1:0]   free_total = '0;
  logic [SECTOR_W-1:0] cur_base   = 16'd2;
  logic [LINK_W-1:0]   cur_count  = 13'd4096;

  out_word_t pending_outcomes [$];
  int        recent_offs [$];
  int        last_alloc = -1;
  int        walk_pos   = -1;
  int        mismatches = 0;

  sector_chain_map_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always #1 clk = ~clk;

  function automatic int unsigned eff_n();
    return (cur_count > MAX_DATA_SECTORS) ? MAX_DATA_SECTORS : cur_count;
  endfunction

  function automatic logic [SECTOR_W-1:0] rel(logic [SECTOR_W-1:0] s);
    return s - cur_base;
  endfunction

  function automatic out_word_t run_action(in_word_t w);
    out_word_t   r;
    int unsigned n, off, hd, cur, steps;
    bit          sec_ok, hd_ok;
    r = '0;
    n = eff_n();
    off = 32'(rel(w.sector));
    hd = 32'(rel(w.chain_head));
    sec_ok = off < n;
    hd_ok = hd < n;
    case (w.action)
      ACT_FORMAT: begin
        for (int i = 0; i < n; i++) begin
          link_model[i] = (i + 1 < n) ? LINK_W'(i + 1) : END_MARK;
          entry_set[i] = 1'b1;
        end
        free_head = (n != 0) ? '0 : END_MARK;
        free_total = LINK_W'(n);
        r.ok = 1'b1;
      end
      ACT_ALLOC: begin
        if (free_head < n) begin
          off = 32'(free_head);
          free_head = link_model[off];
          link_model[off] = END_MARK;
          if (free_total > 0) free_total = free_total - 1'b1;
          r.ok = 1'b1;
          r.result_sector = SECTOR_W'(cur_base + off);
        end else begin
          r.result_is_end = 1'b1;
        end
      end
      ACT_FREE: begin
        if (sec_ok) begin
          link_model[off] = free_head;
          entry_set[off] = 1'b1;
          free_head = LINK_W'(off);
          if (free_total < n) free_total = free_total + 1'b1;
          r.ok = 1'b1;
        end
      end
      ACT_NEXT: begin
        if (sec_ok && link_model[off] < n) begin
          r.ok = 1'b1;
          r.result_sector = SECTOR_W'(cur_base + link_model[off]);
        end else begin
          r.ok = sec_ok;
          r.result_is_end = 1'b1;
        end
      end
      ACT_APPEND: begin
        if (sec_ok && w.head_is_end) begin
          link_model[off] = END_MARK;
          entry_set[off] = 1'b1;
          r.ok = 1'b1;
          r.result_sector = SECTOR_W'(cur_base + off);
        end else if (sec_ok && hd_ok) begin
          cur = hd;
          steps = 0;
          while (steps < n && link_model[cur] < n) begin
            cur = 32'(link_model[cur]);
            steps++;
          end
          if (link_model[cur] >= n) begin
            link_model[cur] = LINK_W'(off);
            link_model[off] = END_MARK;
            entry_set[off] = 1'b1;
            r.ok = 1'b1;
            r.result_sector = SECTOR_W'(cur_base + off);
          end
        end
      end
      ACT_MARK: begin
        if (sec_ok) begin
          link_model[off] = END_MARK;
          entry_set[off] = 1'b1;
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.free_count = free_total;
    return r;
  endfunction

  function automatic logic [SECTOR_W-1:0] pick_sector(int unsigned n);
    if (n == 0 || $urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: return SECTOR_W'($urandom);
        1: return SECTOR_W'(cur_base + n);
        default: return SECTOR_W'(cur_base - 1'b1);
      endcase
    end
    if (recent_offs.size() != 0 && $urandom_range(0, 1) != 0)
      return SECTOR_W'(cur_base + recent_offs[$urandom_range(0, recent_offs.size() - 1)]);
    return SECTOR_W'(cur_base + $urandom_range(0, n - 1));
  endfunction

  // Entries never written since reset are not read: such a next is steered to a
  // sector, and such an append to a chain head, just past the data area.
  function automatic in_word_t make_word();
    in_word_t    w;
    int unsigned n, pick;
    n = eff_n();
    pick = $urandom_range(0, 99);
    w.sector = pick_sector(n);
    w.chain_head = SECTOR_W'($urandom);
    w.head_is_end = 1'($urandom_range(0, 1));
    if (pick < 2) begin
      w.action = ACT_FORMAT;
    end else if (pick < 24) begin
      w.action = ACT_ALLOC;
    end else if (pick < 40) begin
      w.action = ACT_FREE;
    end else if (pick < 60) begin
      w.action = ACT_NEXT;
      if (walk_pos >= 0 && $urandom_range(0, 4) != 0)
        w.sector = SECTOR_W'(cur_base + walk_pos);
    end else if (pick < 88) begin
      w.action = ACT_APPEND;
      w.head_is_end = ($urandom_range(0, 6) == 0);
      if (last_alloc >= 0 && $urandom_range(0, 9) < 7)
        w.sector = SECTOR_W'(cur_base + last_alloc);
      if (recent_offs.size() != 0 && $urandom_range(0, 3) != 0)
        w.chain_head = SECTOR_W'(cur_base +
                                 recent_offs[$urandom_range(0, recent_offs.size() - 1)]);
      else
        w.chain_head = pick_sector(n);
    end else if (pick < 96) begin
      w.action = ACT_MARK;
    end else begin
      w.action = $urandom_range(0, 1) ? ACT_BAD_A : ACT_BAD_B;
    end
    if (w.action == ACT_NEXT && rel(w.sector) < n && !entry_set[rel(w.sector)])
      w.sector = SECTOR_W'(cur_base + n);
    if (w.action == ACT_APPEND && rel(w.sector) < n && !w.head_is_end &&
        rel(w.chain_head) < n && !entry_set[rel(w.chain_head)])
      w.chain_head = SECTOR_W'(cur_base + n);
    return w;
  endfunction

  function automatic plan_row_t op_row(logic [ACTION_W-1:0] act, logic [SECTOR_W-1:0] sec,
                                       logic [SECTOR_W-1:0] head, logic hie);
    plan_row_t r;
    r = '0;
    r.w.action = act;
    r.w.sector = sec;
    r.w.chain_head = head;
    r.w.head_is_end = hie;
    return r;
  endfunction

  function automatic plan_row_t typed_row(logic [ACTION_W-1:0] act, logic [SECTOR_W-1:0] sec,
                                          logic [SECTOR_W-1:0] head, logic hie, logic ok,
                                          logic [SECTOR_W-1:0] rsec, logic rend,
                                          logic [LINK_W-1:0] fc);
    plan_row_t r;
    r = op_row(act, sec, head, hie);
    r.typed = 1'b1;
    r.want.ok = ok;
    r.want.result_sector = rsec;
    r.want.result_is_end = rend;
    r.want.free_count = fc;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    out_word_t pred;
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    pred = run_action(w);
    pending_outcomes.push_back(typed ? want : pred);
    if ((w.action == ACT_ALLOC || w.action == ACT_APPEND) && pred.ok) begin
      recent_offs.push_back(int'(rel(pred.result_sector)));
      if (recent_offs.size() > RECENT_DEPTH) void'(recent_offs.pop_front());
      last_alloc = (w.action == ACT_ALLOC) ? int'(rel(pred.result_sector)) : -1;
    end
    if (w.action == ACT_NEXT)
      walk_pos = (pred.ok && !pred.result_is_end) ? int'(rel(pred.result_sector)) : -1;
    @(negedge clk);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_DATA_BASE) cur_base = val;
    else cur_count = val[LINK_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [SECTOR_W-1:0] want,
                             input logic [SECTOR_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, out_word);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("ok", SECTOR_W'(want.ok), SECTOR_W'(out_word.ok));
        check_field("result_sector", want.result_sector, out_word.result_sector);
        check_field("result_is_end", SECTOR_W'(want.result_is_end),
                    SECTOR_W'(out_word.result_is_end));
        check_field("free_count", SECTOR_W'(want.free_count), SECTOR_W'(out_word.free_count));
      end
    end
  end

  initial begin
    #40_000_000;
    $display("sector_chain_map_allocator test failed");
    $finish;
  end

  initial begin
    plan_row_t             plan [$];
    int                    sent;
    int                    phase_len;
    int                    idle_pct;
    logic [CFG_DATA_W-1:0] base_v;
    logic [CFG_DATA_W-1:0] count_v;
    in_word_t              w;

    plan.push_back(typed_row(ACT_ALLOC, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b1, 13'd0));
    plan.push_back(typed_row(ACT_NEXT, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b1, 13'd0));
    plan.push_back(typed_row(ACT_FREE, 16'd2, 16'd0, 1'b0, 1'b1, 16'd0, 1'b0, 13'd1));
    plan.push_back(typed_row(ACT_NEXT, 16'd2, 16'd0, 1'b0, 1'b1, 16'd0, 1'b1, 13'd1));
    plan.push_back(typed_row(ACT_ALLOC, 16'd0, 16'd0, 1'b0, 1'b1, 16'd2, 1'b0, 13'd0));
    plan.push_back(typed_row(ACT_BAD_A, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'd0, 1'b0, 13'd0));
    plan.push_back(cfg_row(CFG_DATA_BASE, 16'hFFFF));
    plan.push_back(cfg_row(CFG_DATA_COUNT, 16'd5));
    plan.push_back(typed_row(ACT_FORMAT, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 1'b0, 13'd5));
    plan.push_back(typed_row(ACT_ALLOC, 16'd0, 16'd0, 1'b0, 1'b1, 16'hFFFF, 1'b0, 13'd4));
    plan.push_back(typed_row(ACT_ALLOC, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 1'b0, 13'd3));
    plan.push_back(op_row(ACT_APPEND, 16'd0, 16'hFFFF, 1'b0));
    plan.push_back(op_row(ACT_NEXT, 16'hFFFF, 16'd0, 1'b0));
    plan.push_back(typed_row(ACT_NEXT, 16'd4, 16'd0, 1'b0, 1'b0, 16'd0, 1'b1, 13'd3));
    plan.push_back(op_row(ACT_MARK, 16'hFFFF, 16'd0, 1'b0));
    plan.push_back(op_row(ACT_APPEND, 16'd2, 16'hFFFF, 1'b1));
    plan.push_back(op_row(ACT_FREE, 16'd2, 16'd0, 1'b0));
    plan.push_back(op_row(ACT_FREE, 16'd2, 16'd0, 1'b0));
    plan.push_back(op_row(ACT_FREE, 16'd0, 16'd0, 1'b0));
    plan.push_back(op_row(ACT_APPEND, 16'd3, 16'd2, 1'b0));
    plan.push_back(cfg_row(CFG_DATA_BASE, 16'd0));
    plan.push_back(cfg_row(CFG_DATA_COUNT, 16'd0));
    plan.push_back(typed_row(ACT_FORMAT, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 1'b0, 13'd0));
    plan.push_back(typed_row(ACT_ALLOC, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b1, 13'd0));
    plan.push_back(typed_row(ACT_FREE, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 13'd0));
    plan.push_back(cfg_row(CFG_DATA_COUNT, 16'd8191));
    plan.push_back(typed_row(ACT_FORMAT, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 1'b0, 13'd4096));
    plan.push_back(typed_row(ACT_ALLOC, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 1'b0, 13'd4095));
    plan.push_back(typed_row(ACT_APPEND, 16'hFFFF, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 13'd4095));
    plan.push_back(typed_row(ACT_NEXT, 16'd4095, 16'd0, 1'b0, 1'b1, 16'd0, 1'b1, 13'd4095));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_word(plan[i].w, plan[i].typed, plan[i].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0: base_v = 16'd0;
        1: base_v = 16'hFFFF;
        default: base_v = CFG_DATA_W'($urandom);
      endcase
      case ($urandom_range(0, 19))
        0: count_v = 16'd0;
        1: count_v = 16'd4096;
        2: count_v = 16'd8191;
        3: count_v = CFG_DATA_W'($urandom_range(65, 8191));
        default: count_v = CFG_DATA_W'($urandom_range(1, 40));
      endcase
      write_reg(CFG_DATA_BASE, base_v);
      write_reg(CFG_DATA_COUNT, count_v);
      recent_offs.delete();
      last_alloc = -1;
      walk_pos = -1;
      phase_len = (eff_n() > 64) ? 12 : $urandom_range(80, 150);
      idle_pct = $urandom_range(0, 2) * 25;
      if ($urandom_range(0, 9) != 0) begin
        w = make_word();
        w.action = ACT_FORMAT;
        send_word(w, 1'b0, '0);
        sent++;
      end
      for (int k = 0; k < phase_len && sent < RANDOM_WORDS; k++) begin
        if (sent >= RANDOM_WORDS - CALM_TAIL) idle_pct = 0;
        if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 18));
        send_word(make_word(), 1'b0, '0);
        sent++;
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("sector_chain_map_allocator test passed");
    else
      $display("sector_chain_map_allocator test failed");
    $finish;
  end

endmodule

FILE: sector_chain_map_allocator.f
design/scma_pkg.sv
design/scma_ram.sv
design/scma_dp.sv
design/scma_ctrl.sv
design/sector_chain_map_allocator.sv
verif/tb.sv
